// ----- design/nscl_pkg.sv -----
// Shared constants, codes and the pipeline beat type of the nearest-site lookup.
package nscl_pkg;

  localparam int MAX_SITES = 32;

  localparam int COORD_W = 24;
  localparam int COLOR_W = 32;
  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 6;

  localparam int IDX_W  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int SEL_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int DIST_W = SQ_W + 1;

  // Three register stages per site, plus the output register.
  localparam int PIPE_LAT = 3 * MAX_SITES + 1;

  typedef logic [IDX_W-1:0]   cell_idx_t;
  typedef logic [SEL_W-1:0]   sel_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DIFF_W-1:0]  diff_t;
  typedef logic [DIST_W-1:0]  dist_t;

  localparam count_t COUNT_RST = count_t'(1);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_SHADE = 1'b1
  } kind_t;

  // One beat in flight. For a load, sel is the slot, x/y/color the site.
  // For a shade, x/y is the point and sel/color/dsq the best site so far.
  typedef struct packed {
    logic                       valid;
    kind_t                      kind;
    sel_t                       sel;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic        [COLOR_W-1:0]  color;
    dist_t                      dsq;
  } item_t;

endpackage

// ----- design/nscl_cell.sv -----
// One site of the search chain: site storage, difference, square and compare stages.
module nscl_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nscl_pkg::cell_idx_t        cell_idx,
  input  nscl_pkg::count_t           site_count,
  input  nscl_pkg::item_t            item_i,
  output nscl_pkg::item_t            item_o
);

  typedef struct packed {
    nscl_pkg::item_t                         item;
    logic                                    act;
    logic signed [nscl_pkg::DIFF_W-1:0]      dx;
    logic signed [nscl_pkg::DIFF_W-1:0]      dy;
    logic        [nscl_pkg::COLOR_W-1:0]     col;
  } sta_t;

  typedef struct packed {
    nscl_pkg::item_t                         item;
    logic                                    act;
    logic [nscl_pkg::SQ_W-1:0]               sqx;
    logic [nscl_pkg::SQ_W-1:0]               sqy;
    logic [nscl_pkg::COLOR_W-1:0]            col;
  } stb_t;

  logic signed [nscl_pkg::COORD_W-1:0] sx_r;
  logic signed [nscl_pkg::COORD_W-1:0] sy_r;
  logic        [nscl_pkg::COLOR_W-1:0] scol_r;

  sta_t            a_r, a_nxt;
  stb_t            b_r, b_nxt;
  nscl_pkg::item_t c_r, c_nxt;

  logic                                hit_load;
  logic                                active;
  logic                                first;
  logic                                take;
  logic signed [nscl_pkg::PROD_W-1:0]  prod_x;
  logic signed [nscl_pkg::PROD_W-1:0]  prod_y;
  nscl_pkg::dist_t                     sum_sq;

  assign first    = (cell_idx == '0);
  assign hit_load = item_i.valid && (item_i.kind == nscl_pkg::KIND_LOAD) &&
                    (item_i.sel == nscl_pkg::sel_t'(cell_idx));
  // Site zero always takes part; the rest only below the count.
  assign active   = first || (int'(cell_idx) < int'(site_count));

  // A load writes this slot as it passes, so beats ahead of it see old data.
  always_ff @(posedge clk) begin
    if (hit_load) begin
      sx_r   <= item_i.x;
      sy_r   <= item_i.y;
      scol_r <= item_i.color;
    end
  end

  always_comb begin
    a_nxt      = '0;
    a_nxt.item = item_i;
    a_nxt.act  = active;
    a_nxt.dx   = $signed(nscl_pkg::diff_t'({sx_r[nscl_pkg::COORD_W-1], sx_r}) -
                         nscl_pkg::diff_t'({item_i.x[nscl_pkg::COORD_W-1], item_i.x}));
    a_nxt.dy   = $signed(nscl_pkg::diff_t'({sy_r[nscl_pkg::COORD_W-1], sy_r}) -
                         nscl_pkg::diff_t'({item_i.y[nscl_pkg::COORD_W-1], item_i.y}));
    a_nxt.col  = scol_r;
  end

  assign prod_x = $signed(a_r.dx) * $signed(a_r.dx);
  assign prod_y = $signed(a_r.dy) * $signed(a_r.dy);

  always_comb begin
    b_nxt      = '0;
    b_nxt.item = a_r.item;
    b_nxt.act  = a_r.act;
    b_nxt.sqx  = prod_x[nscl_pkg::SQ_W-1:0];
    b_nxt.sqy  = prod_y[nscl_pkg::SQ_W-1:0];
    b_nxt.col  = a_r.col;
  end

  assign sum_sq = nscl_pkg::dist_t'(b_r.sqx) + nscl_pkg::dist_t'(b_r.sqy);
  // Strict less-than keeps the lowest index on a tie.
  assign take = b_r.item.valid && (b_r.item.kind == nscl_pkg::KIND_SHADE) && b_r.act &&
                (first || (sum_sq < b_r.item.dsq));

  always_comb begin
    c_nxt = b_r.item;
    if (take) begin
      c_nxt.dsq   = sum_sq;
      c_nxt.sel   = nscl_pkg::sel_t'(cell_idx);
      c_nxt.color = b_r.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.item.valid <= 1'b0;
      b_r.item.valid <= 1'b0;
      c_r.valid      <= 1'b0;
    end else begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  assign item_o = c_r;

endmodule

// ----- design/nearest_site_color_lookup.sv -----
// Top level: nearest-site color lookup, a chain of per-site compare cells.
// A shade beat's result strobe is driven from the output register after the beat has passed every cell.
// Throughput: one beat (load or shade) per cycle while busy is low; each site owns three pipeline stages
// (difference, square, add and compare), so the chain length sets the latency.
// Reset clears the valid bits and sets site_count to 1; site storage is undefined until loaded.
// busy is high during reset and in the cycle after it, then stays low; results cannot stall.
module nearest_site_color_lookup (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_kind,
  input  logic        [nscl_pkg::SLOT_W-1:0]   in_site_index,
  input  logic signed [nscl_pkg::COORD_W-1:0]  in_site_x,
  input  logic signed [nscl_pkg::COORD_W-1:0]  in_site_y,
  input  logic        [nscl_pkg::COLOR_W-1:0]  in_site_color,
  input  logic signed [nscl_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [nscl_pkg::COORD_W-1:0]  in_point_y,
  input  logic                                 cfg_we,
  input  logic        [nscl_pkg::COUNT_W-1:0]  cfg_site_count,
  output logic                                 out_valid,
  output logic        [nscl_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic        [nscl_pkg::SLOT_W-1:0]   out_nearest_index
);

  logic                           busy_r;
  nscl_pkg::count_t               count_r;
  nscl_pkg::item_t                in_item;
  nscl_pkg::item_t                link [nscl_pkg::MAX_SITES+1];
  logic                           out_valid_r, out_valid_nxt;
  logic [nscl_pkg::COLOR_W-1:0]   out_color_r;
  logic [nscl_pkg::SLOT_W-1:0]    out_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      count_r <= nscl_pkg::COUNT_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        count_r <= cfg_site_count;
      end
    end
  end

  assign busy = busy_r;

  always_comb begin
    in_item       = '0;
    in_item.valid = start && !busy_r;
    in_item.kind  = nscl_pkg::kind_t'(in_kind);
    in_item.color = in_site_color;
    if (in_item.kind == nscl_pkg::KIND_SHADE) begin
      in_item.x = in_point_x;
      in_item.y = in_point_y;
    end else begin
      in_item.sel = nscl_pkg::sel_t'(in_site_index);
      in_item.x   = in_site_x;
      in_item.y   = in_site_y;
    end
  end

  assign link[0] = in_item;

  for (genvar g = 0; g < nscl_pkg::MAX_SITES; g++) begin : g_cell
    nscl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (nscl_pkg::cell_idx_t'(g)),
      .site_count (count_r),
      .item_i     (link[g]),
      .item_o     (link[g+1])
    );
  end

  // Loads drop off the end; only shade beats produce a result.
  assign out_valid_nxt = link[nscl_pkg::MAX_SITES].valid &&
                         (link[nscl_pkg::MAX_SITES].kind == nscl_pkg::KIND_SHADE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_color_r <= link[nscl_pkg::MAX_SITES].color;
      out_index_r <= link[nscl_pkg::MAX_SITES].sel[nscl_pkg::SLOT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_color   = out_color_r;
  assign out_nearest_index = out_index_r;

endmodule

// ----- design/nscl_chk.sv -----
// Port-level checker for the nearest-site lookup and its bind to the top level.
module nscl_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_kind,
  input logic out_valid
);

  // Every accepted shade beat yields exactly one strobe at the fixed latency.
  a_shade_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind) |-> ##(nscl_pkg::PIPE_LAT) out_valid)
    else $error("accepted shade beat produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_kind, nscl_pkg::PIPE_LAT))
    else $error("result strobe without a matching shade beat");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy)
    else $error("busy low in the first cycle after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind nearest_site_color_lookup nscl_chk u_nscl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_valid (out_valid)
);

// ----- dv/nearest_site_color_lookup_tb.sv -----
// Self-checking testbench for the nearest-site color lookup: directed table, then random beats.
module nearest_site_color_lookup_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BEATS  = 150;
  localparam int PHASE_COUNT  = 11;
  localparam int SETTLE_TICKS = nscl_pkg::PIPE_LAT + 4;

  typedef struct packed {
    nscl_pkg::kind_t                kind;
    logic [nscl_pkg::SLOT_W-1:0]    slot;
    logic [nscl_pkg::COORD_W-1:0]   sx;
    logic [nscl_pkg::COORD_W-1:0]   sy;
    logic [nscl_pkg::COLOR_W-1:0]   color;
    logic [nscl_pkg::COORD_W-1:0]   px;
    logic [nscl_pkg::COORD_W-1:0]   py;
  } beat_t;

  typedef struct packed {
    logic [nscl_pkg::COLOR_W-1:0] color;
    logic [nscl_pkg::SLOT_W-1:0]  idx;
  } shade_result_t;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_op_t;

  typedef struct packed {
    row_op_t            op;
    beat_t              beat;
    nscl_pkg::count_t   count;
    logic               typed;
    shade_result_t      want;
  } stim_row_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 in_kind;
  logic        [nscl_pkg::SLOT_W-1:0]   in_site_index;
  logic signed [nscl_pkg::COORD_W-1:0]  in_site_x;
  logic signed [nscl_pkg::COORD_W-1:0]  in_site_y;
  logic        [nscl_pkg::COLOR_W-1:0]  in_site_color;
  logic signed [nscl_pkg::COORD_W-1:0]  in_point_x;
  logic signed [nscl_pkg::COORD_W-1:0]  in_point_y;
  logic                                 cfg_we;
  logic        [nscl_pkg::COUNT_W-1:0]  cfg_site_count;
  logic                                 out_valid;
  logic        [nscl_pkg::COLOR_W-1:0]  out_pixel_color;
  logic        [nscl_pkg::SLOT_W-1:0]   out_nearest_index;

  // Shadow of the site table and the count register.
  logic signed [nscl_pkg::COORD_W-1:0]  site_x_tab [nscl_pkg::MAX_SITES];
  logic signed [nscl_pkg::COORD_W-1:0]  site_y_tab [nscl_pkg::MAX_SITES];
  logic        [nscl_pkg::COLOR_W-1:0]  site_color_tab [nscl_pkg::MAX_SITES];
  bit                                   slot_loaded [nscl_pkg::MAX_SITES];
  nscl_pkg::count_t                     site_count_reg;

  shade_result_t  pending_pixels[$];
  int             mismatches;
  int             sender_idle_pct;
  int unsigned    cycle_count;

  nearest_site_color_lookup u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_site_index     (in_site_index),
    .in_site_x         (in_site_x),
    .in_site_y         (in_site_y),
    .in_site_color     (in_site_color),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .cfg_we            (cfg_we),
    .cfg_site_count    (cfg_site_count),
    .out_valid         (out_valid),
    .out_pixel_color   (out_pixel_color),
    .out_nearest_index (out_nearest_index)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_site_color_lookup_tb NOT OK");
      $finish;
    end
  end

  function automatic int active_sites();
    if (site_count_reg == 0) return 1;
    if (site_count_reg > nscl_pkg::MAX_SITES) return nscl_pkg::MAX_SITES;
    return int'(site_count_reg);
  endfunction

  // Smallest squared distance wins; strict compare keeps the lowest slot on ties.
  function automatic shade_result_t nearest_site(
      input logic signed [nscl_pkg::COORD_W-1:0] px,
      input logic signed [nscl_pkg::COORD_W-1:0] py);
    shade_result_t  res;
    longint         dx;
    longint         dy;
    longint         dsq;
    longint         best;
    int             j;
    best = 0;
    res  = '0;
    for (j = 0; j < active_sites(); j++) begin
      dx  = longint'(site_x_tab[j]) - longint'(px);
      dy  = longint'(site_y_tab[j]) - longint'(py);
      dsq = dx * dx + dy * dy;
      if (j == 0 || dsq < best) begin
        best      = dsq;
        res.idx   = nscl_pkg::SLOT_W'(j);
        res.color = site_color_tab[j];
      end
    end
    return res;
  endfunction

  function automatic logic [nscl_pkg::COORD_W-1:0] pick_coord();
    int v;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      1, 2: begin
        // tight cluster around the origin so ties show up often
        v = int'($urandom_range(16)) - 8;
        return v[nscl_pkg::COORD_W-1:0];
      end
      default: return nscl_pkg::COORD_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(input beat_t b, input logic typed, input shade_result_t want);
    shade_result_t exp_px;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start         <= 1'b1;
    in_kind       <= b.kind;
    in_site_index <= b.slot;
    in_site_x     <= b.sx;
    in_site_y     <= b.sy;
    in_site_color <= b.color;
    in_point_x    <= b.px;
    in_point_y    <= b.py;
    do @(posedge clk); while (busy);
    if (b.kind == nscl_pkg::KIND_LOAD) begin
      site_x_tab[b.slot]     = b.sx;
      site_y_tab[b.slot]     = b.sy;
      site_color_tab[b.slot] = b.color;
      slot_loaded[b.slot]    = 1'b1;
    end else begin
      exp_px         = typed ? want : nearest_site(b.px, b.py);
      pending_pixels = {pending_pixels, exp_px};
    end
  endtask

  // Drain every beat in flight, loads included, before touching the register.
  task automatic set_site_count(input nscl_pkg::count_t value);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_site_count <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    site_count_reg = value;
  endtask

  always @(posedge clk) begin : check_results
    shade_result_t got;
    if (rst_n && out_valid) begin
      got = '{out_pixel_color, out_nearest_index};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: color %h index %0d", got.color, got.idx);
      end else begin
        if (got.color !== pending_pixels[0].color) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel_color mismatch: expected %h got %h",
                     pending_pixels[0].color, got.color);
        end
        if (got.idx !== pending_pixels[0].idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("nearest_index mismatch: expected %0d got %0d",
                     pending_pixels[0].idx, got.idx);
        end
        void'(pending_pixels.pop_front());
      end
    end
  end

  initial begin : stimulus
    stim_row_t         directed_rows [18];
    nscl_pkg::count_t  phase_counts [PHASE_COUNT];
    stim_row_t         row;
    beat_t             b;
    int                p;
    int                i;
    int                j;

    directed_rows = '{
      '{ROW_BEAT, '{nscl_pkg::KIND_LOAD, 5'd0, 24'h7FFFFF, 24'h800000, 32'hFFFFFFFF,
                   24'h7FFFFF, 24'h800000}, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF,
                   24'h800000, 24'h7FFFFF}, 6'd0, 1'b1, '{32'hFFFFFFFF, 5'd0}},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd0, 24'h0, 24'h0, 32'h0,
                   24'h000000, 24'h000000}, 6'd0, 1'b1, '{32'hFFFFFFFF, 5'd0}},
      // count of zero acts as one
      '{ROW_CFG, '0, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_LOAD, 5'd1, 24'h000000, 24'h000000, 32'h00000000,
                   24'hFFFFFF, 24'hFFFFFF}, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd1, 24'h0, 24'h0, 32'h0,
                   24'h000000, 24'h000000}, 6'd0, 1'b1, '{32'hFFFFFFFF, 5'd0}},
      '{ROW_CFG, '0, 6'd2, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd0, 24'h0, 24'h0, 32'h0,
                   24'h000000, 24'h000000}, 6'd0, 1'b1, '{32'h00000000, 5'd1}},
      '{ROW_BEAT, '{nscl_pkg::KIND_LOAD, 5'd2, 24'h000000, 24'h000000, 32'h12345678,
                   24'h7FFFFF, 24'h7FFFFF}, 6'd0, 1'b0, '0},
      '{ROW_CFG, '0, 6'd3, 1'b0, '0},
      // slots one and two sit at the same spot: lower slot wins
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd2, 24'h0, 24'h0, 32'h0,
                   24'h000000, 24'h000000}, 6'd0, 1'b1, '{32'h00000000, 5'd1}},
      '{ROW_BEAT, '{nscl_pkg::KIND_LOAD, 5'd3, 24'hFFFFFF, 24'hFFFFFF, 32'h0F0F0F0F,
                   24'h800000, 24'h800000}, 6'd0, 1'b0, '0},
      '{ROW_CFG, '0, 6'd4, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd0, 24'h0, 24'h0, 32'h0,
                   24'hFFFFFF, 24'hFFFFFF}, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF,
                   24'h7FFFFF, 24'h7FFFFF}, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_LOAD, 5'd1, 24'h800000, 24'h800000, 32'hDEADBEEF,
                   24'h000000, 24'h000000}, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd0, 24'h0, 24'h0, 32'h0,
                   24'h800000, 24'h800000}, 6'd0, 1'b0, '0},
      '{ROW_BEAT, '{nscl_pkg::KIND_SHADE, 5'd0, 24'h0, 24'h0, 32'h0,
                   24'h000080, 24'hFFFF80}, 6'd0, 1'b0, '0}
    };
    phase_counts = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd5, 6'd31, 6'd33, 6'd16, 6'd2, 6'd0, 6'd0};

    mismatches      = 0;
    sender_idle_pct = 17;
    site_count_reg  = nscl_pkg::COUNT_RST;
    for (j = 0; j < nscl_pkg::MAX_SITES; j++) slot_loaded[j] = 1'b0;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_kind        <= nscl_pkg::KIND_LOAD;
    in_site_index  <= '0;
    in_site_x      <= '0;
    in_site_y      <= '0;
    in_site_color  <= '0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    cfg_we         <= 1'b0;
    cfg_site_count <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.op == ROW_CFG) set_site_count(row.count);
      else send_beat(row.beat, row.typed, row.want);
    end

    for (p = 0; p < PHASE_COUNT; p++) begin
      sender_idle_pct = (p < 4) ? 17 : (p < 8) ? 80 : 0;
      set_site_count((p >= 9) ? nscl_pkg::count_t'($urandom_range(63)) : phase_counts[p]);
      for (i = 0; i < PHASE_BEATS; i++) begin
        b.kind  = ($urandom_range(9) < 7) ? nscl_pkg::KIND_SHADE : nscl_pkg::KIND_LOAD;
        b.slot  = nscl_pkg::SLOT_W'($urandom);
        b.sx    = pick_coord();
        b.sy    = pick_coord();
        b.color = $urandom;
        b.px    = pick_coord();
        b.py    = pick_coord();
        // never shade over a slot that has not been loaded: fill it first
        if (b.kind == nscl_pkg::KIND_SHADE) begin
          for (j = 0; j < active_sites(); j++) begin
            if (!slot_loaded[j]) begin
              b.kind = nscl_pkg::KIND_LOAD;
              b.slot = nscl_pkg::SLOT_W'(j);
              break;
            end
          end
        end
        send_beat(b, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (pending_pixels.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("nearest_site_color_lookup_tb OK");
    end else begin
      $display("nearest_site_color_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule
